@@ src/ebr_pkg.sv @@
// Shared constants and types for the emulation-prevention byte remover.
package ebr_pkg;

  localparam int BYTE_W         = 8;
  localparam int WORD_W         = 32;
  localparam int SIZE_W         = 17;
  localparam int LANE_W         = 2;
  localparam int RUN_W          = 2;
  localparam int MAX_UNIT_BYTES = 65536;

  // Emulation-prevention byte and the saturating counts
  localparam logic [BYTE_W-1:0] EPB_BYTE     = 8'h03;
  localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'h00;
  localparam logic [RUN_W-1:0]  RUN_SAT      = 2'd2;
  localparam logic [RUN_W-1:0]  HEAD_SAT     = 2'd2;
  localparam logic [LANE_W-1:0] LANE_LAST    = 2'd3;
  localparam logic [BYTE_W-1:0] PAD_RESET    = 8'hFF;
  localparam logic [SIZE_W-1:0] MAX_UNIT     = SIZE_W'(MAX_UNIT_BYTES);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SIZE_W-1:0] size_t;

endpackage

@@ src/ebr_in_if.sv @@
// Byte request channel: one raw NAL byte and its last-byte mark.
interface ebr_in_if
  import ebr_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ src/ebr_out_if.sv @@
// Word request channel: packed word, unit close flag and padded size.
interface ebr_out_if
  import ebr_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t word;
  logic  word_valid;
  logic  unit_end;
  size_t padded_size;

  modport source (output valid, output word, output word_valid, output unit_end,
                  output padded_size, input ready);
  modport sink   (input valid, input word, input word_valid, input unit_end,
                  input padded_size, output ready);
endinterface

@@ src/emulation_byte_remover_word_packer.sv @@
// Top level: emulation-prevention byte removal and big-endian word packing.
//
// in_ch carries one NAL byte per request with last_byte on the unit's final
// byte. Every 0x03 that follows two or more zero bytes, past the first two
// bytes of the unit, is dropped. Kept bytes are packed four to a word, first
// byte in bits 31..24, and each full word leaves on out_ch. The last byte
// closes the unit: a partial word is filled with pad_byte and the padded byte
// count is reported with unit_end set.
// The user must write pad_byte through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block itself does not enforce it. Timing: a result
// appears on out_ch the cycle after its byte is accepted. The rate is one
// byte per cycle, set by the single output register, while it is not stalled.
// Reset clears the unit state and the output register and sets pad_byte to
// 0xFF. When the receiver stalls, the result waits in the output register and
// in_ch.ready falls only while that register is full and not being taken.
module emulation_byte_remover_word_packer
  import ebr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  byte_t       cfg_wr_data,
  ebr_in_if.sink      in_ch,
  ebr_out_if.source   out_ch
);

  // Registers
  byte_t                 pad_byte;
  logic [RUN_W-1:0]      zero_run, zero_run_next;
  logic [RUN_W-1:0]      head_count, head_count_next;
  logic [23:0]           partial_word, partial_word_next;
  logic [LANE_W-1:0]     lane_index, lane_index_next;
  size_t                 kept_count, kept_count_next;
  logic                  res_valid, res_valid_next;
  word_t                 res_word, res_word_next;
  logic                  res_word_valid, res_word_valid_next;
  logic                  res_unit_end, res_unit_end_next;
  size_t                 res_size, res_size_next;

  logic                  in_fire;
  logic                  drop;
  logic                  full;
  logic                  produce;
  word_t                 full_word;
  logic [SIZE_W:0]       size_sum;
  logic [SIZE_W:0]       size_round;
  size_t                 size_val;

  assign in_ch.ready = !res_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_byte <= PAD_RESET;
    end else if (cfg_wr_en) begin
      pad_byte <= cfg_wr_data;
    end
  end

  // Drop decision, run tracking and packing
  always_comb begin
    drop = (head_count >= HEAD_SAT) && (in_ch.data_byte == EPB_BYTE) &&
           (zero_run >= RUN_SAT);

    if (in_ch.data_byte == ZERO_BYTE) begin
      zero_run_next = (zero_run >= RUN_SAT) ? RUN_SAT : zero_run + 2'd1;
    end else begin
      zero_run_next = '0;
    end
    head_count_next = (head_count < HEAD_SAT) ? head_count + 2'd1 : head_count;

    full              = 1'b0;
    full_word         = '0;
    partial_word_next = partial_word;
    lane_index_next   = lane_index;
    kept_count_next   = kept_count;
    if (!drop) begin
      if (kept_count < MAX_UNIT) begin
        kept_count_next = kept_count + 1'b1;
      end
      if (lane_index == LANE_LAST) begin
        full              = 1'b1;
        full_word         = {partial_word, in_ch.data_byte};
        partial_word_next = '0;
        lane_index_next   = '0;
      end else begin
        partial_word_next = {partial_word[15:0], in_ch.data_byte};
        lane_index_next   = lane_index + 2'd1;
      end
    end

    // Padded size: round up to a multiple of four, clamp to the maximum
    size_sum   = {1'b0, kept_count_next} + (SIZE_W+1)'(3);
    size_round = size_sum & ~((SIZE_W+1)'(3));
    if (size_round > {1'b0, MAX_UNIT}) begin
      size_val = MAX_UNIT;
    end else begin
      size_val = size_round[SIZE_W-1:0];
    end

    // Result assembly
    produce             = full || in_ch.last_byte;
    res_word_next       = full_word;
    res_word_valid_next = full;
    res_unit_end_next   = in_ch.last_byte;
    res_size_next       = '0;
    if (in_ch.last_byte) begin
      res_size_next = size_val;
      if (!full) begin
        unique case (lane_index_next)
          2'd1: begin
            res_word_next       = {partial_word_next[7:0], pad_byte, pad_byte, pad_byte};
            res_word_valid_next = 1'b1;
          end
          2'd2: begin
            res_word_next       = {partial_word_next[15:0], pad_byte, pad_byte};
            res_word_valid_next = 1'b1;
          end
          2'd3: begin
            res_word_next       = {partial_word_next[23:0], pad_byte};
            res_word_valid_next = 1'b1;
          end
          default: begin
            res_word_next       = '0;
            res_word_valid_next = 1'b0;
          end
        endcase
      end
      // Unit closes: state returns to its reset value
      zero_run_next     = '0;
      head_count_next   = '0;
      partial_word_next = '0;
      lane_index_next   = '0;
      kept_count_next   = '0;
    end

    if (in_fire && produce) begin
      res_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  // Unit state
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run     <= '0;
      head_count   <= '0;
      partial_word <= '0;
      lane_index   <= '0;
      kept_count   <= '0;
    end else if (in_fire) begin
      zero_run     <= zero_run_next;
      head_count   <= head_count_next;
      partial_word <= partial_word_next;
      lane_index   <= lane_index_next;
      kept_count   <= kept_count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && produce) begin
      res_word       <= res_word_next;
      res_word_valid <= res_word_valid_next;
      res_unit_end   <= res_unit_end_next;
      res_size       <= res_size_next;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.word        = res_word;
  assign out_ch.word_valid  = res_word_valid;
  assign out_ch.unit_end    = res_unit_end;
  assign out_ch.padded_size = res_size;

  // Mid-unit results always carry a full word and no size
  a_mid_unit_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_unit_end |-> res_word_valid && (res_size == '0))
    else $error("mid-unit result without a full word or with a size");

  // Reported size is a multiple of four and within the limit
  a_size_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_unit_end |-> (res_size[1:0] == 2'b00) && (res_size <= MAX_UNIT))
    else $error("padded size out of range");

  // The last byte leaves the unit state cleared
  a_unit_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.last_byte |=> (lane_index == '0) && (kept_count == '0) &&
                                   (head_count == '0) && (zero_run == '0))
    else $error("unit state not cleared after last byte");

  // A byte that closes a unit always yields a result
  a_close_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.last_byte |=> res_valid && res_unit_end)
    else $error("unit closed without a result");

endmodule

@@ dv/tb_emulation_byte_remover_word_packer.sv @@
// Self-checking testbench: emulation-prevention byte removal and word packing.
module tb_emulation_byte_remover_word_packer;
  import ebr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;  // cycles with no accepted request
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    word_t word;
    logic  word_valid;
    logic  unit_end;
    size_t padded_size;
  } result_t;

  typedef struct packed {
    byte_t   data;
    logic    last;
    logic    typed;  // expected result written below rather than predicted
    result_t res;
  } row_t;

  logic  clk;
  logic  rst;
  logic  cfg_wr_en;
  byte_t cfg_wr_data;

  ebr_in_if  in_ch ();
  ebr_out_if out_ch ();

  emulation_byte_remover_word_packer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Directed units (pad byte at its reset value 0xFF)
  row_t dir_rows [22] = '{
    // single zero byte
    '{8'h00, 1'b1, 1'b1, '{32'h00FF_FFFF, 1'b1, 1'b1, 17'd4}},
    // 0x03 as the first byte is never dropped
    '{8'h03, 1'b1, 1'b1, '{32'h03FF_FFFF, 1'b1, 1'b1, 17'd4}},
    // 00 00 03 01: the 03 goes, zero head bytes count toward the run
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'h01, 1'b1, 1'b1, '{32'h0000_01FF, 1'b1, 1'b1, 17'd4}},
    // dropped 03 clears the run, so the later 03 after one zero stays
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h03, 1'b1, 1'b1, '{32'h0000_0003, 1'b1, 1'b1, 17'd4}},
    // full word mid-unit, then a dropped last byte with nothing pending
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 17'd0}},
    '{8'h03, 1'b1, 1'b1, '{32'h0000_0000, 1'b0, 1'b1, 17'd4}},
    // all-ones bytes, partial final word padded
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 17'd0}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1, 17'd8}}
  };

  // Predictor state
  logic [RUN_W-1:0]  zrun;
  logic [1:0]        head_seen;
  logic [23:0]       held_bytes;
  logic [LANE_W-1:0] held_lanes;
  size_t             kept_bytes;
  byte_t             pad_val;

  result_t pending_words [$];
  int      fails;
  int      burst_left;
  bit      hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Strip one byte and pack it; returns the result it causes, if any
  task automatic strip_pack(input byte_t b, input logic last, output bit made,
                            output result_t r);
    bit          drop;
    bit          full;
    word_t       w;
    logic [17:0] rounded;
    int          k;
    drop = head_seen >= HEAD_SAT && b == EPB_BYTE && zrun >= RUN_SAT;
    full = 1'b0;
    w    = '0;
    made = 1'b0;
    r    = '0;
    if (b == ZERO_BYTE) zrun = (zrun >= RUN_SAT) ? RUN_SAT : zrun + 1'b1;
    else zrun = '0;
    if (head_seen < HEAD_SAT) head_seen++;
    if (!drop) begin
      if (kept_bytes < MAX_UNIT) kept_bytes++;
      if (held_lanes == LANE_LAST) begin
        w          = {held_bytes, b};
        full       = 1'b1;
        held_bytes = '0;
        held_lanes = '0;
      end else begin
        held_bytes = {held_bytes[15:0], b};
        held_lanes++;
      end
    end
    if (!last) begin
      if (full) begin
        r    = '{w, 1'b1, 1'b0, '0};
        made = 1'b1;
      end
    end else begin
      if (!full && held_lanes != 0) begin
        w = word_t'(held_bytes);
        for (k = int'(held_lanes); k < 4; k++) w = {w[23:0], pad_val};
        full = 1'b1;
      end
      rounded = ({1'b0, kept_bytes} + 18'd3) & ~18'd3;
      if (rounded > 18'(MAX_UNIT_BYTES)) rounded = 18'(MAX_UNIT_BYTES);
      r          = '{full ? w : '0, full, 1'b1, size_t'(rounded)};
      made       = 1'b1;
      zrun       = '0;
      head_seen  = '0;
      held_bytes = '0;
      held_lanes = '0;
      kept_bytes = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    fails++;
    if (fails <= 50) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Offer one byte request in bursts with random gaps; predict on acceptance
  task automatic send_request(input byte_t b, input logic last, input bit typed,
                              input result_t typed_res);
    int      gap;
    bit      made;
    result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    strip_pack(b, last, made, r);
    if (typed) pending_words.push_back(typed_res);
    else if (made) pending_words.push_back(r);
  endtask

  // Sender pauses until every expected word is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pad(input byte_t v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pad_val = v;
  endtask

  // Bias toward zero runs and 0x03 so removal is exercised often
  function automatic byte_t pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3) return ZERO_BYTE;
    if (sel <= 5) return EPB_BYTE;
    if (sel == 6) return byte_t'($urandom_range(1, 2));
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic run_units(input int n);
    int sent;
    int len;
    int i;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      for (i = 0; i < len; i++) send_request(pick_byte(), i == len - 1, 1'b0, '0);
      sent += len;
    end
  endtask

  // Stimulus
  initial begin : stim
    int    ph;
    byte_t pads [5];
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    fails      = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    zrun       = '0;
    head_seen  = '0;
    held_bytes = '0;
    held_lanes = '0;
    kept_bytes = '0;
    pad_val    = PAD_RESET;
    pads[0] = 8'h00;
    pads[1] = 8'hFF;
    pads[2] = byte_t'($urandom_range(0, 255));
    pads[3] = byte_t'($urandom_range(0, 255));
    pads[4] = byte_t'($urandom_range(0, 255));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[j])
      send_request(dir_rows[j].data, dir_rows[j].last, dir_rows[j].typed, dir_rows[j].res);

    for (ph = 0; ph < 5; ph++) begin
      set_pad(pads[ph]);
      // receiver holds off while bytes keep coming, so the block backs up
      if (ph == 2) hold_req = 1'b1;
      run_units(PHASE_ITEMS);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Receiver: stall pattern changes every so often, plus the long hold-off
  initial begin : rx_side
    int tick;
    int rx_mode;
    tick    = 0;
    rx_mode = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        tick++;
        if (tick % 97 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (tick % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Compare each accepted word request with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result word=%h", out_ch.word));
      end else begin
        want = pending_words.pop_front();
        if (out_ch.word !== want.word)
          report_mismatch($sformatf("word %h, want %h", out_ch.word, want.word));
        if (out_ch.word_valid !== want.word_valid)
          report_mismatch($sformatf("word_valid %b, want %b", out_ch.word_valid,
                                    want.word_valid));
        if (out_ch.unit_end !== want.unit_end)
          report_mismatch($sformatf("unit_end %b, want %b", out_ch.unit_end,
                                    want.unit_end));
        if (out_ch.padded_size !== want.padded_size)
          report_mismatch($sformatf("padded_size %0d, want %0d", out_ch.padded_size,
                                    want.padded_size));
      end
    end
  end

  // Watchdog on cycles with no accepted request on either side
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
